/* rtl/udc_pkg.sv */
// ============================================================================
// udc_pkg: shared types and constants of the Unix time to calendar date unit
// Pipeline stage record, stage count and the fixed constants of the
// day-count to Gregorian date formulas.
// ============================================================================
package udc_pkg;

    // number of register stages from input to output
    localparam int unsigned NUM_STAGES = 12;

    // time of day
    localparam int unsigned SEC_DIV_PRE  = 15;   // t/60 = (t>>2)/15
    localparam int unsigned HOUR_DIV_PRE = 3;    // t/24 = (t>>3)/3

    // century correction: a = (4*days + A_OFS) / A_DIV + A_BASE
    localparam logic [18:0] A_OFS  = 19'd102032;
    localparam logic [18:0] A_DIV  = 19'd146097;
    localparam logic [18:0] A_DIV2 = 19'd292194;
    localparam logic [4:0]  A_BASE = 5'd15;

    // b = days + B_OFS + a - a/4
    localparam logic [21:0] B_OFS = 22'd2442113;

    // c = (20*b - C_OFS) / C_DIV
    localparam logic [25:0] C_MUL = 26'd20;
    localparam logic [25:0] C_OFS = 26'd2442;
    localparam int unsigned C_DIV = 7305;

    // d = b - 365*c - c/4
    localparam logic [9:0] D_MUL = 10'd365;

    // e = d*1000 / 30601
    localparam logic [18:0] E_MUL = 19'd1000;
    localparam int unsigned E_DIV = 30601;

    // f = d - 30*e - e*601/1000
    localparam logic [4:0]  F_MUL  = 5'd30;
    localparam logic [13:0] G_MUL  = 14'd601;
    localparam int unsigned G_DIV  = 1000;

    // month and year fold-back
    localparam logic [4:0]  E_LAST_SAME = 5'd13;
    localparam logic [12:0] Y_OFS_LO    = 13'd4716;
    localparam logic [12:0] Y_OFS_HI    = 13'd4715;
    localparam logic [4:0]  M_OFS_LO    = 5'd1;
    localparam logic [4:0]  M_OFS_HI    = 5'd13;

    // weekday: 1970-01-01 was a Thursday
    localparam logic [16:0] WD_OFS = 17'd4;
    localparam int unsigned WD_DIV = 7;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic        zero;      // input timestamp was zero
        logic [5:0]  t_lo;      // low bits of the timestamp
        logic [26:0] q1;        // seconds / 60
        logic [20:0] q2;        // seconds / 3600
        logic [15:0] days;      // whole days
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [21:0] b;
        logic [16:0] wx;        // days + weekday offset
        logic [12:0] wq;        // wx / 7
        logic [2:0]  wd;        // weekday
        logic [25:0] x20;
        logic [12:0] c;
        logic [9:0]  d;
        logic [18:0] x1000;
        logic [4:0]  e;
        logic [13:0] x601;
        logic [3:0]  g;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
    } t_pipe;

endpackage

/* rtl/udc_cdiv.sv */
// ============================================================================
// udc_cdiv: unsigned division by a constant
// Exact quotient of a WIDTH-bit value through a reciprocal multiply and a
// right shift; the reciprocal is rounded up so no correction step is needed.
// ============================================================================
module udc_cdiv #(
    parameter int unsigned WIDTH   = 16,
    parameter int unsigned DIVISOR = 3
) (
    input  logic [WIDTH-1:0]                i_num,
    output logic [WIDTH-$clog2(DIVISOR):0]  o_quo
);
    localparam int unsigned SHIFT = $clog2(DIVISOR);
    localparam int unsigned QW    = WIDTH - SHIFT + 1;
    localparam int unsigned PW    = 2 * WIDTH + 1;
    localparam longint unsigned P2     = 64'd1 << (WIDTH + SHIFT);
    localparam longint unsigned MULT_L = (P2 + longint'(DIVISOR) - 64'd1) / DIVISOR;
    localparam logic [WIDTH:0]  MULT   = MULT_L[WIDTH:0];

    logic [PW-1:0] w_prod;

    assign w_prod = PW'(i_num) * PW'(MULT);
    assign o_quo  = w_prod[PW-1 -: QW];

endmodule

/* rtl/unix_time_to_calendar_date_unit.sv */
// ============================================================================
// unix_time_to_calendar_date_unit: Unix seconds to calendar date and time
// Converts an unsigned 32-bit Unix time into second, minute, hour, year,
// month, day of month and weekday over a twelve-stage pipeline.
// ============================================================================
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------------------
//  input    | i_in_valid    | o_in_stall    | i_unix_seconds
//  output   | o_out_valid   | i_out_stall   | o_status .. o_day_of_week
//
//  One beat enters per cycle while o_in_stall is low. The stage split
//  follows the chain of constant divisions (60, 60, 24, 7, 7305, 30601,
//  1000), one reciprocal multiply per stage with its operand setup.
//  Synchronous active-low reset clears the stage valid bits only.
//  A stage loads whenever it is empty or the stage after it moves, so a
//  stalled output beat holds while empty stages behind it still fill.
//
module unix_time_to_calendar_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_unix_seconds,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_day_of_week
);
    import udc_pkg::*;

    localparam int unsigned LAST = NUM_STAGES - 1;

    t_pipe r_stg [NUM_STAGES];
    t_pipe n_stg [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    // quotients from the constant dividers
    logic [26:0] w_q1;
    logic [21:0] w_q2;
    logic [16:0] w_days;
    logic [14:0] w_wq;
    logic [13:0] w_c;
    logic [4:0]  w_e;
    logic [4:0]  w_g;

    logic [18:0] w_a_sum;
    logic [4:0]  w_a;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when the next one moves.
    // ------------------------------------------------------------------
    always_comb begin
        w_en[LAST] = !r_vld[LAST] || !i_out_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_stall = !w_en[0];

    // ------------------------------------------------------------------
    // Dividers, one per stage that needs one
    // ------------------------------------------------------------------
    udc_cdiv #(.WIDTH(30), .DIVISOR(SEC_DIV_PRE)) u_div_min (
        .i_num (i_unix_seconds[31:2]),
        .o_quo (w_q1)
    );

    udc_cdiv #(.WIDTH(25), .DIVISOR(SEC_DIV_PRE)) u_div_hour (
        .i_num (r_stg[0].q1[26:2]),
        .o_quo (w_q2)
    );

    udc_cdiv #(.WIDTH(18), .DIVISOR(HOUR_DIV_PRE)) u_div_day (
        .i_num (r_stg[1].q2[20:3]),
        .o_quo (w_days)
    );

    udc_cdiv #(.WIDTH(17), .DIVISOR(WD_DIV)) u_div_week (
        .i_num (r_stg[3].wx),
        .o_quo (w_wq)
    );

    udc_cdiv #(.WIDTH(26), .DIVISOR(C_DIV)) u_div_c (
        .i_num (r_stg[4].x20),
        .o_quo (w_c)
    );

    udc_cdiv #(.WIDTH(19), .DIVISOR(E_DIV)) u_div_e (
        .i_num (r_stg[7].x1000),
        .o_quo (w_e)
    );

    udc_cdiv #(.WIDTH(14), .DIVISOR(G_DIV)) u_div_g (
        .i_num (r_stg[9].x601),
        .o_quo (w_g)
    );

    // century correction terms for stage 4
    assign w_a_sum = {1'b0, r_stg[2].days, 2'b00} + A_OFS;
    assign w_a     = A_BASE + 5'(w_a_sum >= A_DIV) + 5'(w_a_sum >= A_DIV2);

    // ------------------------------------------------------------------
    // Stage logic: each stage copies the record and fills in its fields.
    // Remainders are taken modulo the field width; the true values fit.
    // ------------------------------------------------------------------
    always_comb begin
        // stage 1: seconds / 60
        n_stg[0]      = '0;
        n_stg[0].zero = (i_unix_seconds == 32'd0);
        n_stg[0].t_lo = i_unix_seconds[5:0];
        n_stg[0].q1   = w_q1;

        // stage 2: second, minutes total / 60
        n_stg[1]     = r_stg[0];
        n_stg[1].sec = r_stg[0].t_lo - r_stg[0].q1[5:0] * 6'd60;
        n_stg[1].q2  = w_q2[20:0];

        // stage 3: minute, whole days
        n_stg[2]      = r_stg[1];
        n_stg[2].min  = r_stg[1].q1[5:0] - r_stg[1].q2[5:0] * 6'd60;
        n_stg[2].days = w_days[15:0];

        // stage 4: hour, b, weekday operand
        n_stg[3]    = r_stg[2];
        n_stg[3].hr = r_stg[2].q2[4:0] - r_stg[2].days[4:0] * 5'd24;
        n_stg[3].b  = 22'(r_stg[2].days) + B_OFS + 22'(w_a) - 22'(w_a[4:2]);
        n_stg[3].wx = 17'(r_stg[2].days) + WD_OFS;

        // stage 5: 20*b - offset, weekday quotient
        n_stg[4]     = r_stg[3];
        n_stg[4].x20 = 26'(r_stg[3].b) * C_MUL - C_OFS;
        n_stg[4].wq  = w_wq[12:0];

        // stage 6: c, weekday
        n_stg[5]    = r_stg[4];
        n_stg[5].c  = w_c[12:0];
        n_stg[5].wd = r_stg[4].wx[2:0] - r_stg[4].wq[2:0] * 3'd7;

        // stage 7: day within the March-based year
        n_stg[6]   = r_stg[5];
        n_stg[6].d = r_stg[5].b[9:0] - r_stg[5].c[9:0] * D_MUL
                     - 10'(r_stg[5].c[12:2]);

        // stage 8: d * 1000
        n_stg[7]       = r_stg[6];
        n_stg[7].x1000 = 19'(r_stg[6].d) * E_MUL;

        // stage 9: month index e
        n_stg[8]   = r_stg[7];
        n_stg[8].e = w_e;

        // stage 10: e * 601
        n_stg[9]      = r_stg[8];
        n_stg[9].x601 = 14'(r_stg[8].e) * G_MUL;

        // stage 11: e*601 / 1000
        n_stg[10]   = r_stg[9];
        n_stg[10].g = w_g[3:0];

        // stage 12: day of month, fold month and year, blank on zero input
        n_stg[11]      = r_stg[10];
        n_stg[11].mday = r_stg[10].d[4:0] - r_stg[10].e * F_MUL - 5'(r_stg[10].g);
        if (r_stg[10].e <= E_LAST_SAME) begin
            n_stg[11].year  = 12'(r_stg[10].c - Y_OFS_LO);
            n_stg[11].month = 4'(r_stg[10].e - M_OFS_LO);
        end else begin
            n_stg[11].year  = 12'(r_stg[10].c - Y_OFS_HI);
            n_stg[11].month = 4'(r_stg[10].e - M_OFS_HI);
        end
        if (r_stg[10].zero) begin
            n_stg[11].sec   = '0;
            n_stg[11].min   = '0;
            n_stg[11].hr    = '0;
            n_stg[11].wd    = '0;
            n_stg[11].year  = '0;
            n_stg[11].month = '0;
            n_stg[11].mday  = '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage registers: valid bits reset, payload loads on enable
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat
    // ------------------------------------------------------------------
    assign o_out_valid    = r_vld[LAST];
    assign o_status       = r_stg[LAST].zero ? STATUS_INVALID : STATUS_OK;
    assign o_second       = r_stg[LAST].sec;
    assign o_minute       = r_stg[LAST].min;
    assign o_hour         = r_stg[LAST].hr;
    assign o_year         = r_stg[LAST].year;
    assign o_month        = r_stg[LAST].month;
    assign o_day_of_month = r_stg[LAST].mday;
    assign o_day_of_week  = r_stg[LAST].wd;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_stall_when_drained : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall
    ) else $error("input stalled while output is free");

    a_invalid_blank : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_year == 12'd0 && o_month == 4'd0 &&
            o_day_of_month == 5'd0 && o_second == 6'd0 && o_day_of_week == 3'd0
    ) else $error("invalid beat carries nonzero fields");

    a_valid_date_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status |-> o_year >= 12'd1970 && o_year <= 12'd2106 &&
            o_month >= 4'd1 && o_month <= 4'd12 &&
            o_day_of_month >= 5'd1 && o_day_of_week <= 3'd6
    ) else $error("date field out of range");

    a_valid_time_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status |-> o_second <= 6'd59 && o_minute <= 6'd59 &&
            o_hour <= 5'd23
    ) else $error("time field out of range");

endmodule

/* tb/unix_time_to_calendar_date_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// unix_time_to_calendar_date_unit_tb: self-checking bench for the Unix time
// to calendar date unit.
// A short table of directed timestamps (zero, epoch edges, leap days, century
// years, the top of the 32-bit range) runs first, then random timestamps in
// four traffic phases. Every output beat is compared field by field with the
// oldest predicted date, hand-typed or from the bench's calendar arithmetic.
// ============================================================================
module unix_time_to_calendar_date_unit_tb;

    import udc_pkg::*;

    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned RANDOM_BEATS = 283;   // per traffic phase
    localparam int unsigned NUM_PHASES   = 4;

    // weekday codes, 0 is Sunday
    localparam logic [2:0] SUNDAY   = 3'd0;
    localparam logic [2:0] THURSDAY = 3'd4;
    localparam logic [2:0] FRIDAY   = 3'd5;

    localparam logic [31:0] SECS_PER_DAY = 32'd86400;
    localparam logic [31:0] LAST_DAY     = 32'd49709;

    typedef struct packed {
        logic        status;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
    } cal_fields_t;

    // One directed row: the timestamp, and a hand-typed date where it is
    // obvious. Rows without one are checked against the calendar arithmetic.
    typedef struct packed {
        logic [31:0] secs;
        logic        typed;
        cal_fields_t want;
    } date_row_t;

    localparam cal_fields_t NO_DATE = '0;

    localparam int unsigned NUM_ROWS = 22;
    localparam date_row_t DATE_ROWS [NUM_ROWS] = '{
        // zero timestamp: invalid, every date field clear
        '{32'd0,          1'b1, '{STATUS_INVALID, 6'd0, 6'd0, 5'd0, 12'd0, 4'd0,
                                  5'd0, 3'd0}},
        '{32'd1,          1'b1, '{STATUS_OK, 6'd1, 6'd0, 5'd0, 12'd1970, 4'd1,
                                  5'd1, THURSDAY}},
        '{32'd59,         1'b1, '{STATUS_OK, 6'd59, 6'd0, 5'd0, 12'd1970, 4'd1,
                                  5'd1, THURSDAY}},
        '{32'd3599,       1'b1, '{STATUS_OK, 6'd59, 6'd59, 5'd0, 12'd1970, 4'd1,
                                  5'd1, THURSDAY}},
        '{32'd86399,      1'b1, '{STATUS_OK, 6'd59, 6'd59, 5'd23, 12'd1970, 4'd1,
                                  5'd1, THURSDAY}},
        '{32'd86400,      1'b1, '{STATUS_OK, 6'd0, 6'd0, 5'd0, 12'd1970, 4'd1,
                                  5'd2, FRIDAY}},
        // top of the range: 2106-02-07 06:28:15, a Sunday
        '{32'hFFFF_FFFF,  1'b1, '{STATUS_OK, 6'd15, 6'd28, 5'd6, 12'd2106, 4'd2,
                                  5'd7, SUNDAY}},
        '{32'd31535999,   1'b0, NO_DATE},    // last second of 1970
        '{32'd31536000,   1'b0, NO_DATE},
        '{32'd68169600,   1'b0, NO_DATE},    // first leap day
        '{32'd946684799,  1'b0, NO_DATE},    // year 2000 turnover
        '{32'd946684800,  1'b0, NO_DATE},
        '{32'd951782399,  1'b0, NO_DATE},
        '{32'd951782400,  1'b0, NO_DATE},    // leap day of a 400-year
        '{32'd951868800,  1'b0, NO_DATE},
        '{32'd1709164800, 1'b0, NO_DATE},
        '{32'h7FFF_FFFF,  1'b0, NO_DATE},
        '{32'h8000_0000,  1'b0, NO_DATE},
        '{32'd4102444800, 1'b0, NO_DATE},    // 2100, a non-leap century
        '{32'd4107456000, 1'b0, NO_DATE},
        '{32'h5555_5555,  1'b0, NO_DATE},
        '{32'hAAAA_AAAA,  1'b0, NO_DATE}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic [31:0] unix_seconds;
    logic        out_stall;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_status;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [2:0]  o_day_of_week;

    cal_fields_t pending_dates [$];   // predicted dates, oldest first
    cal_fields_t beat_want;           // date predicted for the beat on the input
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    unix_time_to_calendar_date_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_unix_seconds (unix_seconds),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_status       (o_status),
        .o_second       (o_second),
        .o_minute       (o_minute),
        .o_hour         (o_hour),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_day_of_week  (o_day_of_week)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Calendar arithmetic over 32-bit unsigned integers: split off the time
    // of day, map the day count to a Julian-style date with January and
    // February as months 13 and 14 of the year before, then fold back.
    function automatic cal_fields_t unix_to_calendar(input logic [31:0] secs);
        cal_fields_t r;
        int unsigned t, a, b, c, d, e, f;
        int unsigned early, mm, yy, sum;
        r = '0;
        if (secs == 32'd0) begin
            r.status = STATUS_INVALID;
            return r;
        end
        t = secs;
        r.status = STATUS_OK;
        r.second = 6'(t % 60);
        t = t / 60;
        r.minute = 6'(t % 60);
        t = t / 60;
        r.hour = 5'(t % 24);
        t = t / 24;

        a = (4 * t + 102032) / 146097 + 15;
        b = t + 2442113 + a - a / 4;
        c = (20 * b - 2442) / 7305;
        d = b - 365 * c - c / 4;
        e = d * 1000 / 30601;
        f = d - e * 30 - e * 601 / 1000;
        if (e <= 13) begin
            c = c - 4716;
            e = e - 1;
        end else begin
            c = c - 4715;
            e = e - 13;
        end
        r.year = 12'(c);
        r.month = 4'(e);
        r.mday = 5'(f);

        // weekday by the Zeller-type congruence, March-based months
        early = (e <= 2) ? 1 : 0;
        mm = e + 12 * early - 2;
        yy = c - early;
        sum = (f - 1) + (13 * mm - 1) / 5 + yy + yy / 4 - yy / 100 + yy / 400;
        r.wday = 3'(((sum % 7) + 1) % 7);
        return r;
    endfunction

    // Bias the random timestamps: plain 32-bit values, day boundaries (where
    // month and year carries happen), times within a day, and both range ends.
    function automatic logic [31:0] pick_seconds();
        logic [31:0] day;
        day = $urandom_range(0, LAST_DAY);
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom();
            3: return day * SECS_PER_DAY;
            4: return day * SECS_PER_DAY + SECS_PER_DAY - 32'd1;
            5: return day * SECS_PER_DAY + 32'($urandom_range(0, 86399));
            6: return 32'($urandom_range(0, 255));
            default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one beat, with random idle cycles ahead of it, and hold it
    // until it is taken. Returns on the falling edge after acceptance.
    task automatic send_beat(input logic [31:0] secs, input cal_fields_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        beat_want = want;
        unix_seconds <= secs;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every predicted date has come out.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_dates.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Receiver side: random stall, drawn fresh every cycle.
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Scoreboard: record every accepted input beat, then compare every
    // accepted output beat with the oldest prediction. Both are done in one
    // block so a beat that enters and leaves at the same edge stays in order.
    always @(posedge i_clk) begin
        cal_fields_t want;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall)
                pending_dates.push_back(beat_want);
            if (o_out_valid && !out_stall) begin
                if (pending_dates.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected output beat, expected none, actual year %0d",
                             $time, o_year);
                end else begin
                    want = pending_dates.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("second", 32'(want.second), 32'(o_second));
                    check_field("minute", 32'(want.minute), 32'(o_minute));
                    check_field("hour", 32'(want.hour), 32'(o_hour));
                    check_field("year", 32'(want.year), 32'(o_year));
                    check_field("month", 32'(want.month), 32'(o_month));
                    check_field("day_of_month", 32'(want.mday), 32'(o_day_of_month));
                    check_field("day_of_week", 32'(want.wday), 32'(o_day_of_week));
                end
            end
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #(2_000_000);
        $display("unix_time_to_calendar_date_unit_tb failed");
        $finish;
    end

    initial begin
        logic [31:0] secs;
        in_valid = 1'b0;
        unix_seconds = '0;
        i_rst_n = 1'b0;
        beat_want = '0;
        mismatch_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, back to back, no stalls
        foreach (DATE_ROWS[i]) begin
            send_beat(DATE_ROWS[i].secs,
                      DATE_ROWS[i].typed ? DATE_ROWS[i].want
                                         : unix_to_calendar(DATE_ROWS[i].secs));
        end

        // random phases: open, sender gaps, receiver stalls, both
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            // start every phase from an empty pipeline
            drain_pipeline();
            for (int n = 0; n < RANDOM_BEATS; n++) begin
                secs = pick_seconds();
                send_beat(secs, unix_to_calendar(secs));
            end
        end

        drain_pipeline();
        repeat (2 * NUM_STAGES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("unix_time_to_calendar_date_unit_tb passed");
        else
            $display("unix_time_to_calendar_date_unit_tb failed");
        $finish;
    end

endmodule
